// ===== rtl/core/cnc_pkg.sv =====
// cnc_pkg: shared types, constants and register codes for the 3x3 filter core.
// No dependencies.
package cnc_pkg;

	localparam int MAX_LINE_BYTES_DEF = 4096;
	localparam int MAX_CHANNELS_DEF   = 4;

	localparam int PIX_W    = 8;
	localparam int RAM_W    = 2 * PIX_W;
	localparam int ROW_W    = 12;
	localparam int OCOL_W   = 12;
	localparam int ACC_W    = 20;
	localparam int CSUM_W   = 12;
	localparam int NTAPS    = 9;
	localparam int IDX_W    = 4;
	localparam int DIV_STEPS = 8;
	localparam int DCNT_W   = 3;

	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_COEF_TOP    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COEF_MIDDLE = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_COEF_BOTTOM = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_LINE_BYTES  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CHANNELS    = 3'd4;

	localparam logic [23:0] COEF_TOP_RST    = 24'h010201;
	localparam logic [23:0] COEF_MIDDLE_RST = 24'h020402;
	localparam logic [23:0] COEF_BOTTOM_RST = 24'h010201;
	localparam logic [12:0] LINE_BYTES_RST  = 13'd1024;
	localparam logic [2:0]  CHANNELS_RST    = 3'd1;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
	localparam logic [ROW_W-1:0] ROW_MAX = 12'd4095;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MEM,
		S_CALC,
		S_OUT
	} top_state_t;

	typedef enum logic [2:0] {
		A_IDLE,
		A_MAC,
		A_PREP,
		A_DIV,
		A_DONE
	} arith_phase_t;

	typedef struct packed {
		logic             done;
		logic [PIX_W-1:0] value;
	} arith_res_t;

endpackage

// ===== rtl/core/conv3x3_normalized_clamp_core.sv =====
// conv3x3_normalized_clamp_core: 3x3 filter over interleaved pixel bytes.
// A byte is accepted only in the idle state. A border byte passes the memory stage only;
// a filtered byte also runs the serial 9-tap MAC and, unless saturated, zero or with
// coefficient sum zero, the 8-step divider, and waits for the output register to be free.
// No new byte is taken until the last one is through. Reset: counters, window and config
// to defaults; line RAM is not cleared. Uses cnc_pkg, cnc_line_ram, cnc_window, cnc_arith.
module conv3x3_normalized_clamp_core import cnc_pkg::*; #(
	parameter int MAX_LINE_BYTES = MAX_LINE_BYTES_DEF,
	parameter int MAX_CHANNELS   = MAX_CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [PIX_W-1:0]   pixel_in,
	input  logic               frame_start,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PIX_W-1:0]   pixel_out,
	output logic [ROW_W-1:0]   out_row,
	output logic [OCOL_W-1:0]  out_col
);

	localparam int CNT_W = $clog2(MAX_LINE_BYTES);
	localparam int LEN_W = $clog2(MAX_LINE_BYTES + 1);
	localparam int CMP_W = (LEN_W > 13) ? LEN_W : 13;
	localparam int OC_W  = (CNT_W > OCOL_W) ? CNT_W : OCOL_W;

	logic [23:0] coef_top_q, coef_mid_q, coef_bot_q;
	logic [12:0] line_bytes_q;
	logic [2:0]  channels_q;

	top_state_t state_q, state_d;

	logic [CNT_W-1:0] column_q;
	logic [ROW_W-1:0] row_q;
	logic [CNT_W-1:0] pos_col_q;
	logic [ROW_W-1:0] pos_row_q;
	logic [PIX_W-1:0] px_q;

	logic              out_valid_q;
	logic [PIX_W-1:0]  pixel_out_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [OCOL_W-1:0] out_col_q;

	logic              accept;
	logic              cfg_wr;
	logic [REG_IDX_W-1:0] reg_idx;
	logic [CMP_W-1:0]  lb_ext;
	logic [LEN_W-1:0]  eff_len;
	logic [2:0]        eff_ch;
	logic [CNT_W-1:0]  pos_col;
	logic [ROW_W-1:0]  pos_row;
	logic [LEN_W-1:0]  col_nxt;
	logic              produce;
	logic              arith_start;
	logic              out_load;
	logic [OC_W-1:0]   col_diff;

	logic [RAM_W-1:0]            ram_rd;
	logic [NTAPS-1:0][PIX_W-1:0] taps;
	logic [NTAPS-1:0][PIX_W-1:0] coefs;
	arith_res_t                  arith_res;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign reg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_top_q   <= COEF_TOP_RST;
			coef_mid_q   <= COEF_MIDDLE_RST;
			coef_bot_q   <= COEF_BOTTOM_RST;
			line_bytes_q <= LINE_BYTES_RST;
			channels_q   <= CHANNELS_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_COEF_TOP:    coef_top_q   <= pwdata[23:0];
				REG_COEF_MIDDLE: coef_mid_q   <= pwdata[23:0];
				REG_COEF_BOTTOM: coef_bot_q   <= pwdata[23:0];
				REG_LINE_BYTES:  line_bytes_q <= pwdata[12:0];
				REG_CHANNELS:    channels_q   <= pwdata[2:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_COEF_TOP:    prdata = {8'd0, coef_top_q};
			REG_COEF_MIDDLE: prdata = {8'd0, coef_mid_q};
			REG_COEF_BOTTOM: prdata = {8'd0, coef_bot_q};
			REG_LINE_BYTES:  prdata = {19'd0, line_bytes_q};
			REG_CHANNELS:    prdata = {29'd0, channels_q};
			default:         prdata = '0;
		endcase
	end

	// effective geometry
	always_comb begin
		lb_ext = CMP_W'(line_bytes_q);
		priority if (lb_ext < CMP_W'(3)) begin
			eff_len = LEN_W'(3);
		end else if (lb_ext > CMP_W'(MAX_LINE_BYTES)) begin
			eff_len = LEN_W'(MAX_LINE_BYTES);
		end else begin
			eff_len = LEN_W'(lb_ext);
		end
		priority if (channels_q == 3'd0) begin
			eff_ch = 3'd1;
		end else if (channels_q > 3'(MAX_CHANNELS)) begin
			eff_ch = 3'(MAX_CHANNELS);
		end else begin
			eff_ch = channels_q;
		end
	end

	assign accept  = in_valid & in_ready;
	assign pos_col = frame_start ? '0 : column_q;
	assign pos_row = frame_start ? '0 : row_q;
	assign col_nxt = LEN_W'(pos_col) + LEN_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (accept) begin
			if (col_nxt >= eff_len) begin
				column_q <= '0;
				row_q    <= (pos_row == ROW_MAX) ? pos_row : pos_row + ROW_W'(1);
			end else begin
				column_q <= CNT_W'(col_nxt);
				row_q    <= pos_row;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_col_q <= pos_col;
			pos_row_q <= pos_row;
			px_q      <= pixel_in;
		end
	end

	cnc_line_ram #(
		.DEPTH (MAX_LINE_BYTES),
		.ADDR_W(CNT_W)
	) u_ram (
		.clk    (clk),
		.wr_en  (state_q == S_MEM),
		.wr_addr(pos_col_q),
		.wr_data({ram_rd[PIX_W-1:0], px_q}),
		.rd_en  (accept),
		.rd_addr(pos_col),
		.rd_data(ram_rd)
	);

	cnc_window #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift_en(state_q == S_MEM),
		.top     (ram_rd[RAM_W-1:PIX_W]),
		.mid     (ram_rd[PIX_W-1:0]),
		.px      (px_q),
		.ch      (eff_ch),
		.taps    (taps)
	);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			coefs[k]   = coef_top_q[8*k +: 8];
			coefs[3+k] = coef_mid_q[8*k +: 8];
			coefs[6+k] = coef_bot_q[8*k +: 8];
		end
	end

	cnc_arith u_arith (
		.clk   (clk),
		.arst_n(arst_n),
		.start (arith_start),
		.pix   (taps),
		.coef  (coefs),
		.res   (arith_res)
	);

	assign produce = (pos_row_q >= ROW_W'(2)) && (pos_col_q >= CNT_W'({eff_ch, 1'b0}));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		arith_start = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_MEM;
				end
			end
			S_MEM: begin
				if (produce) begin
					arith_start = 1'b1;
					state_d     = S_CALC;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_CALC: begin
				if (arith_res.done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// output register
	assign col_diff = OC_W'(pos_col_q) - OC_W'(eff_ch);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pixel_out_q <= arith_res.value;
			out_row_q   <= pos_row_q - ROW_W'(1);
			out_col_q   <= col_diff[OCOL_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;

`ifndef ASSERT_OFF
	a_accept_to_mem: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_MEM)
		else $error("accepted request did not reach memory stage");

	a_mem_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MEM |=> (state_q == S_IDLE || state_q == S_CALC))
		else $error("memory stage left to an illegal state");

	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		arith_res.done |-> state_q == S_CALC)
		else $error("arithmetic done outside calculation");

	a_out_row_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_row != '0)
		else $error("result row from a border line");
`endif

endmodule

// ===== rtl/core/cnc_line_ram.sv =====
// cnc_line_ram: single-port-write, single-read synchronous RAM holding both
// previous lines ({two back, one back}). Uses cnc_pkg.
module cnc_line_ram import cnc_pkg::*; #(
	parameter int DEPTH  = MAX_LINE_BYTES_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [RAM_W-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [RAM_W-1:0]  rd_data
);

	logic [RAM_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/cnc_window.sv =====
// cnc_window: three-row tap shift line and stride-dependent 3x3 tap selection.
// Uses cnc_pkg.
module cnc_window import cnc_pkg::*; #(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        shift_en,
	input  logic [PIX_W-1:0]            top,
	input  logic [PIX_W-1:0]            mid,
	input  logic [PIX_W-1:0]            px,
	input  logic [2:0]                  ch,
	output logic [NTAPS-1:0][PIX_W-1:0] taps
);

	localparam int TAP_COLS = 2 * MAX_CHANNELS + 1;

	logic [PIX_W-1:0] taps_q [3][TAP_COLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < TAP_COLS; k++) begin
					taps_q[r][k] <= '0;
				end
			end
		end else if (shift_en) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < TAP_COLS - 1; k++) begin
					taps_q[r][k] <= taps_q[r][k+1];
				end
			end
			taps_q[0][TAP_COLS-1] <= top;
			taps_q[1][TAP_COLS-1] <= mid;
			taps_q[2][TAP_COLS-1] <= px;
		end
	end

	// per tap: mux over the fixed positions of each legal stride
	always_comb begin
		taps = '0;
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				for (int c = 1; c <= MAX_CHANNELS; c++) begin
					if (ch == 3'(c)) begin
						taps[r*3+k] = taps_q[r][TAP_COLS-1-(2-k)*c];
					end
				end
			end
		end
	end

endmodule

// ===== rtl/core/cnc_arith.sv =====
// cnc_arith: serial multiply-accumulate over the nine taps, then sign handling,
// saturation and an eight-step restoring divide. Uses cnc_pkg.
module cnc_arith import cnc_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [NTAPS-1:0][PIX_W-1:0] pix,
	input  logic [NTAPS-1:0][PIX_W-1:0] coef,
	output arith_res_t                  res
);

	localparam int MAGA_W = ACC_W - 1;
	localparam int MAGC_W = CSUM_W - 1;

	arith_phase_t phase_q, phase_d;

	logic        [IDX_W-1:0]  idx_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [CSUM_W-1:0] csum_q;
	logic        [MAGC_W-1:0] rem_q;
	logic        [MAGC_W-1:0] magc_q;
	logic        [PIX_W-1:0]  dvd_q;
	logic        [PIX_W-1:0]  quo_q;
	logic        [DCNT_W-1:0] dcnt_q;
	logic        [PIX_W-1:0]  value_q;

	logic signed [PIX_W-1:0]   coef_sel;
	logic signed [PIX_W:0]     pix_sel;
	logic signed [2*PIX_W:0]   prod;
	logic                      acc_neg;
	logic                      csum_neg;
	logic        [ACC_W-1:0]   acc_abs;
	logic        [CSUM_W-1:0]  csum_abs;
	logic        [MAGA_W-1:0]  maga;
	logic        [MAGC_W-1:0]  magc;
	logic                      over;
	logic        [MAGC_W:0]    trial;
	logic                      qbit;
	logic        [MAGC_W:0]    trial_sub;

	always_comb begin
		coef_sel  = $signed(coef[idx_q]);
		pix_sel   = $signed({1'b0, pix[idx_q]});
		prod      = coef_sel * pix_sel;
		acc_neg   = acc_q[ACC_W-1];
		csum_neg  = csum_q[CSUM_W-1];
		acc_abs   = acc_neg ? (~acc_q + ACC_W'(1)) : acc_q;
		csum_abs  = csum_neg ? (~csum_q + CSUM_W'(1)) : csum_q;
		maga      = acc_abs[MAGA_W-1:0];
		magc      = csum_abs[MAGC_W-1:0];
		over      = maga >= {magc, {PIX_W{1'b0}}};
		trial     = {rem_q, dvd_q[PIX_W-1]};
		qbit      = trial >= {1'b0, magc_q};
		trial_sub = trial - {1'b0, magc_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= A_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		res.done = 1'b0;
		res.value = value_q;
		unique case (phase_q)
			A_IDLE: begin
				if (start) begin
					phase_d = A_MAC;
				end
			end
			A_MAC: begin
				if (idx_q == IDX_W'(NTAPS - 1)) begin
					phase_d = A_PREP;
				end
			end
			A_PREP: begin
				if (csum_q == '0 || acc_q == '0 || (acc_neg ^ csum_neg) || over) begin
					phase_d = A_DONE;
				end else begin
					phase_d = A_DIV;
				end
			end
			A_DIV: begin
				if (dcnt_q == DCNT_W'(DIV_STEPS - 1)) begin
					phase_d = A_DONE;
				end
			end
			A_DONE: begin
				res.done = 1'b1;
				phase_d  = A_IDLE;
			end
			default: begin
				phase_d = A_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			A_IDLE: begin
				if (start) begin
					idx_q  <= '0;
					acc_q  <= '0;
					csum_q <= '0;
				end
			end
			A_MAC: begin
				idx_q  <= idx_q + IDX_W'(1);
				acc_q  <= acc_q + ACC_W'(prod);
				csum_q <= csum_q + CSUM_W'(coef_sel);
			end
			A_PREP: begin
				priority if (csum_q == '0) begin
					if (acc_neg) begin
						value_q <= '0;
					end else if (|acc_q[ACC_W-2:PIX_W]) begin
						value_q <= PIX_MAX;
					end else begin
						value_q <= acc_q[PIX_W-1:0];
					end
				end else if (acc_q == '0 || (acc_neg ^ csum_neg)) begin
					value_q <= '0;
				end else if (over) begin
					value_q <= PIX_MAX;
				end else begin
					rem_q  <= maga[MAGA_W-1:PIX_W];
					dvd_q  <= maga[PIX_W-1:0];
					magc_q <= magc;
					quo_q  <= '0;
					dcnt_q <= '0;
				end
			end
			A_DIV: begin
				rem_q  <= qbit ? trial_sub[MAGC_W-1:0] : trial[MAGC_W-1:0];
				dvd_q  <= {dvd_q[PIX_W-2:0], 1'b0};
				quo_q  <= {quo_q[PIX_W-2:0], qbit};
				dcnt_q <= dcnt_q + DCNT_W'(1);
				if (dcnt_q == DCNT_W'(DIV_STEPS - 1)) begin
					value_q <= {quo_q[PIX_W-2:0], qbit};
				end
			end
			A_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== tb/conv3x3_filter_checker.sv =====
`timescale 1ns / 100ps
// conv3x3_filter_checker: watches the APB port and both streams of the 3x3 filter core,
// predicts every filtered byte from its own copy of the registers, line stores and window,
// and compares results in order. Uses cnc_pkg.
module conv3x3_filter_checker import cnc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic               pready,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [PIX_W-1:0]   pixel_in,
	input  logic               frame_start,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [PIX_W-1:0]   pixel_out,
	input  logic [ROW_W-1:0]   out_row,
	input  logic [OCOL_W-1:0]  out_col,
	output int                 mismatches,
	output int                 awaited
);

	localparam int TAP_LAST = 2 * MAX_CHANNELS_DEF;

	typedef struct packed {
		logic [PIX_W-1:0]  pix;
		logic [ROW_W-1:0]  row;
		logic [OCOL_W-1:0] col;
	} filtered_t;

	filtered_t        filtered_q[$];
	logic [PIX_W-1:0] line_prev[MAX_LINE_BYTES_DEF];
	logic [PIX_W-1:0] line_older[MAX_LINE_BYTES_DEF];
	logic [PIX_W-1:0] taps[3][TAP_LAST+1];
	logic [23:0]      coef_rows[3];
	logic [12:0]      line_cfg;
	logic [2:0]       chan_cfg;
	int               col_pos;
	int               row_pos;
	int               err_tally = 0;

	task automatic report_mismatch(input string what, input int got, input int want);
		err_tally++;
		if (err_tally <= 50)
			$display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
	endtask

	task automatic filter_byte(input logic [PIX_W-1:0] px, input logic fs);
		int               len;
		int               ch;
		int               acc;
		int               csum;
		int               quot;
		int               tmp;
		int               slot;
		logic [PIX_W-1:0] above2;
		logic [PIX_W-1:0] above1;
		logic signed [7:0] w;
		filtered_t        res;
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		len = (int'(line_cfg) < 3) ? 3 :
			(int'(line_cfg) > MAX_LINE_BYTES_DEF) ? MAX_LINE_BYTES_DEF : int'(line_cfg);
		ch = (chan_cfg == 0) ? 1 :
			(int'(chan_cfg) > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF : int'(chan_cfg);
		slot = col_pos % MAX_LINE_BYTES_DEF;
		above2 = line_older[slot];
		above1 = line_prev[slot];
		line_older[slot] = above1;
		line_prev[slot] = px;
		for (int r = 0; r < 3; r++)
			for (int k = 0; k < TAP_LAST; k++)
				taps[r][k] = taps[r][k+1];
		taps[0][TAP_LAST] = above2;
		taps[1][TAP_LAST] = above1;
		taps[2][TAP_LAST] = px;
		if (row_pos >= 2 && col_pos >= 2 * ch) begin
			acc = 0;
			csum = 0;
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					w = coef_rows[r][8*k +: 8];
					acc += int'(w) * int'(taps[r][TAP_LAST - (2 - k) * ch]);
					csum += int'(w);
				end
			end
			quot = (csum != 0) ? acc / csum : acc;
			if (quot > int'(PIX_MAX))
				quot = int'(PIX_MAX);
			if (quot < 0)
				quot = 0;
			res.pix = quot[PIX_W-1:0];
			tmp = row_pos - 1;
			res.row = tmp[ROW_W-1:0];
			tmp = col_pos - ch;
			res.col = tmp[OCOL_W-1:0];
			filtered_q.push_back(res);
		end
		col_pos++;
		if (col_pos >= len) begin
			col_pos = 0;
			if (row_pos < int'(ROW_MAX))
				row_pos++;
		end
	endtask

	task automatic check_result();
		filtered_t want;
		if (filtered_q.size() == 0) begin
			report_mismatch("unrequested result, pixel_out", int'(pixel_out), -1);
		end else begin
			want = filtered_q.pop_front();
			if (pixel_out !== want.pix)
				report_mismatch("pixel_out", int'(pixel_out), int'(want.pix));
			if (out_row !== want.row)
				report_mismatch("out_row", int'(out_row), int'(want.row));
			if (out_col !== want.col)
				report_mismatch("out_col", int'(out_col), int'(want.col));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_rows[0] = COEF_TOP_RST;
			coef_rows[1] = COEF_MIDDLE_RST;
			coef_rows[2] = COEF_BOTTOM_RST;
			line_cfg = LINE_BYTES_RST;
			chan_cfg = CHANNELS_RST;
			col_pos = 0;
			row_pos = 0;
			for (int r = 0; r < 3; r++)
				for (int k = 0; k <= TAP_LAST; k++)
					taps[r][k] = '0;
			filtered_q.delete();
			awaited <= 0;
			mismatches <= err_tally;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_COEF_TOP:    coef_rows[0] = pwdata[23:0];
					REG_COEF_MIDDLE: coef_rows[1] = pwdata[23:0];
					REG_COEF_BOTTOM: coef_rows[2] = pwdata[23:0];
					REG_LINE_BYTES:  line_cfg = pwdata[12:0];
					REG_CHANNELS:    chan_cfg = pwdata[2:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				filter_byte(pixel_in, frame_start);
			if (out_valid && out_ready)
				check_result();
			awaited <= filtered_q.size();
			mismatches <= err_tally;
		end
	end

endmodule

// ===== tb/tb_conv3x3_normalized_clamp_core.sv =====
`timescale 1ns / 100ps
// tb_conv3x3_normalized_clamp_core: stimulus and verdict for the 3x3 filter core.
// Directed frames, random frames over many register settings, a long sink stall,
// a mid-line shrink and a line length above range. Checking is in conv3x3_filter_checker.
module tb_conv3x3_normalized_clamp_core;
	import cnc_pkg::*;

	localparam int WATCHDOG_LIMIT    = 5000;
	localparam int SETTLE_CYCLES     = 30;
	localparam int SQUEEZE_LEN       = 400;
	localparam int RANDOM_ITEMS      = 1300;
	localparam int ABOVE_RANGE_ITEMS = 200;

	// directed frames, first byte in the top bits
	localparam logic [9*8-1:0]  SOBEL_PIX   = 72'hFF0000_00FF00_FF8000;
	localparam logic [16*8-1:0] RESTART_PIX = 128'h00FF00_FF00FF_80_00FF00_FF00FF_00FF00;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic [PIX_W-1:0]   pixel_in;
	logic               frame_start;
	logic               out_valid;
	logic               out_ready;
	logic [PIX_W-1:0]   pixel_out;
	logic [ROW_W-1:0]   out_row;
	logic [OCOL_W-1:0]  out_col;
	int                 mismatches;
	int                 awaited;
	int                 squeeze_asked = 0;
	int                 squeeze_seen = 0;
	int                 calm_items = 0;
	int                 idle_cycles = 0;

	conv3x3_normalized_clamp_core dut (.*);
	conv3x3_filter_checker checker_i (.*);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [23:0] rand_coef_row();
		logic [23:0] row;
		for (int k = 0; k < 3; k++) begin
			case ($urandom_range(0, 5))
				0:       row[8*k +: 8] = 8'h80;
				1:       row[8*k +: 8] = 8'h7F;
				2, 3:    row[8*k +: 8] = 8'($urandom_range(0, 8) - 4);
				default: row[8*k +: 8] = 8'($urandom_range(0, 255));
			endcase
		end
		return row;
	endfunction

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [23:0] c_top, input logic [23:0] c_mid,
			input logic [23:0] c_bot, input logic [12:0] len, input logic [2:0] ch);
		write_reg(REG_COEF_TOP, PDATA_W'(c_top));
		write_reg(REG_COEF_MIDDLE, PDATA_W'(c_mid));
		write_reg(REG_COEF_BOTTOM, PDATA_W'(c_bot));
		write_reg(REG_LINE_BYTES, PDATA_W'(len));
		write_reg(REG_CHANNELS, PDATA_W'(ch));
	endtask

	task automatic send_byte(input logic [PIX_W-1:0] px, input logic fs);
		int gap;
		in_valid <= 1'b1;
		pixel_in <= px;
		frame_start <= fs;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		if (calm_items > 0) begin
			calm_items--;
		end else begin
			if ($urandom_range(0, 49) == 0)
				calm_items = $urandom_range(40, 150);
			gap = pick_gap();
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// stray_odds: one in that many bytes restarts the frame, 0 for never
	task automatic stream_bytes(input int count, input bit fresh, input int stray_odds,
			input int squeeze_at);
		logic [PIX_W-1:0] px;
		logic             fs;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0:       px = '0;
				1:       px = PIX_MAX;
				default: px = PIX_W'($urandom_range(0, 255));
			endcase
			if (i == 0)
				fs = fresh;
			else
				fs = (stray_odds > 0) && ($urandom_range(1, stray_odds) == 1);
			if (i == squeeze_at)
				squeeze_asked <= squeeze_asked + 1;
			send_byte(px, fs);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : sink_side
		int run;
		int gap;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (squeeze_seen != squeeze_asked) begin
				out_ready <= 1'b0;
				repeat (SQUEEZE_LEN) @(posedge clk);
				squeeze_seen++;
			end else begin
				run = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
				out_ready <= 1'b1;
				repeat (run) @(posedge clk);
				gap = pick_gap();
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [23:0] c_top;
		logic [23:0] c_mid;
		logic [23:0] c_bot;
		logic [12:0] len;
		logic [2:0]  ch;
		int          eff_len;
		int          count;
		int          sent;
		int          s;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		pixel_in = '0;
		frame_start = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// edge kernel, zero coefficient sum, line and channel values below range
		set_config(24'hFF0001, 24'hFE0002, 24'hFF0001, 13'd0, 3'd0);
		for (int i = 0; i < 9; i++)
			send_byte(SOBEL_PIX[8*(8-i) +: 8], i == 0);
		drain();
		// extreme coefficients, negative sum, frame restarted mid-line
		set_config(24'h807F80, 24'h7F807F, 24'h807F80, 13'd2, 3'd1);
		for (int i = 0; i < 16; i++)
			send_byte(RESTART_PIX[8*(15-i) +: 8], i == 0 || i == 7);
		drain();

		// sink held off while the source keeps pushing
		set_config(rand_coef_row(), rand_coef_row(), rand_coef_row(), 13'd32, 3'd1);
		stream_bytes(320, 1'b1, 0, 100);
		drain();
		sent = 320;

		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				len = 13'($urandom_range(0, 2));
			else
				len = 13'($urandom_range(3, 48));
			ch = 3'($urandom_range(0, 7));
			c_top = rand_coef_row();
			c_mid = rand_coef_row();
			c_bot = rand_coef_row();
			if ($urandom_range(0, 3) == 0) begin
				s = 0;
				for (int k = 0; k < 3; k++) begin
					s += $signed(c_top[8*k +: 8]) + $signed(c_bot[8*k +: 8]);
					if (k != 1)
						s += $signed(c_mid[8*k +: 8]);
				end
				if (s >= -127 && s <= 128)
					c_mid[15:8] = 8'(-s);
			end
			eff_len = (len < 3) ? 3 : int'(len);
			count = eff_len * $urandom_range(3, 8) + $urandom_range(0, eff_len - 1);
			set_config(c_top, c_mid, c_bot, len, ch);
			stream_bytes(count, 1'b1, 300, -1);
			drain();
			sent += count;
		end

		// line shortened while part way along a line
		set_config(COEF_TOP_RST, COEF_MIDDLE_RST, COEF_BOTTOM_RST, 13'd12, 3'd2);
		stream_bytes(12 * 3 + 9, 1'b1, 0, -1);
		drain();
		write_reg(REG_LINE_BYTES, PDATA_W'(5));
		stream_bytes(5 * 4, 1'b0, 0, -1);
		drain();

		// line length above range, widest channel stride: no wrap within the first line
		set_config(rand_coef_row(), rand_coef_row(), rand_coef_row(), 13'h1FFF, 3'd7);
		stream_bytes(ABOVE_RANGE_ITEMS, 1'b1, 0, -1);
		drain();

		if (mismatches == 0 && awaited == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
